[hdl/npal_pkg.sv]
// Shared types, constants and helpers for the nearest point angle lookup.
package npal_pkg;

  localparam int AngleW     = 16;
  localparam int IndexW     = 16;
  localparam int CountW     = 17;
  localparam int CoordMaxW  = 31;
  localparam int SlotLimit  = 65536;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_SKIP
  } op_e;

  typedef struct packed {
    op_e                           op;
    logic [IndexW-1:0]             index;
    logic signed [CoordMaxW-1:0]   x;
    logic signed [CoordMaxW-1:0]   y;
    logic [AngleW-1:0]             angle_x;
    logic [AngleW-1:0]             angle_y;
  } cmd_t;

  function automatic int store_depth(int depth);
    return (depth < SlotLimit) ? depth : SlotLimit;
  endfunction

endpackage

[hdl/npal_front.sv]
// Input stage: accepts words, classifies them into commands and feeds the queue.
module npal_front #(
  parameter int TABLE_DEPTH = 65536,
  parameter int COORD_BITS  = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [npal_pkg::IndexW-1:0]   entry_index_i,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic signed [npal_pkg::AngleW-1:0] load_angle_x_i,
  input  logic signed [npal_pkg::AngleW-1:0] load_angle_y_i,
  output npal_pkg::cmd_t                cmd_o,
  output logic                          push_o,
  input  logic                          full_i
);

  localparam int StoreDepth = npal_pkg::store_depth(TABLE_DEPTH);
  localparam int CountW     = npal_pkg::CountW;
  localparam int CoordMaxW  = npal_pkg::CoordMaxW;

  logic           valid_q, valid_d;
  npal_pkg::cmd_t cmd_q, cmd_d;
  logic           accept;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;
  assign cmd_o      = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (!valid_q || !full_i) begin
      valid_d = in_valid_i;
    end
  end

  always_comb begin
    cmd_d         = cmd_q;
    cmd_d.index   = entry_index_i;
    cmd_d.x       = CoordMaxW'(point_x_i);
    cmd_d.y       = CoordMaxW'(point_y_i);
    cmd_d.angle_x = load_angle_x_i;
    cmd_d.angle_y = load_angle_y_i;
    if (req_type_i) begin
      cmd_d.op = npal_pkg::OP_QUERY;
    end else if ({1'b0, entry_index_i} < CountW'(StoreDepth)) begin
      cmd_d.op = npal_pkg::OP_LOAD;
    end else begin
      cmd_d.op = npal_pkg::OP_SKIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

[hdl/npal_fifo.sv]
// Short command queue between the input stage and the scan engine.
module npal_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  npal_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output npal_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  localparam int Depth = npal_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  npal_pkg::cmd_t        slots_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hdl/npal_back.sv]
// Scan engine: holds the point table, runs loads and nearest-point scans, drives results.
module npal_back #(
  parameter int TABLE_DEPTH = 65536,
  parameter int COORD_BITS  = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  npal_pkg::cmd_t                     cmd_i,
  input  logic                               cmd_valid_i,
  output logic                               cmd_pop_o,
  input  logic [npal_pkg::CountW-1:0]        entry_count_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [npal_pkg::AngleW-1:0] found_angle_x_o,
  output logic signed [npal_pkg::AngleW-1:0] found_angle_y_o,
  output logic [npal_pkg::IndexW-1:0]        found_index_o,
  output logic                               table_empty_o
);

  localparam int StoreDepth = npal_pkg::store_depth(TABLE_DEPTH);
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int CountW     = npal_pkg::CountW;
  localparam int AngleW     = npal_pkg::AngleW;
  localparam int IndexW     = npal_pkg::IndexW;
  localparam int MagW       = COORD_BITS + 1;
  localparam int SqW        = 2 * MagW;
  localparam int DistW      = SqW + 1;
  localparam int MemW       = 2 * COORD_BITS + 2 * AngleW;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [AddrW-1:0] idx;
  } tag_t;

  logic [1:0]                    state_q, state_d;
  logic [AddrW-1:0]              cnt_q, cnt_d;
  logic [AddrW-1:0]              last_q, last_d;
  logic signed [COORD_BITS-1:0]  qx_q, qy_q;
  logic                          empty_q, empty_d;
  logic [CountW-1:0]             scan_len;
  logic                          mem_we, rd_en, take_query, out_load;

  logic [MemW-1:0]               table_mem [StoreDepth];
  logic [MemW-1:0]               rd_q;

  logic                          v1_q, v2_q, v3_q, v4_q;
  tag_t                          t1_q, t2_q, t3_q, t4_q;
  logic [MagW-1:0]               mx2_q, my2_q;
  logic [SqW-1:0]                sqx3_q, sqy3_q;
  logic [DistW-1:0]              dist4_q;
  logic [AngleW-1:0]             ax2_q, ay2_q, ax3_q, ay3_q, ax4_q, ay4_q;

  logic signed [COORD_BITS-1:0]  ex, ey;
  logic signed [MagW-1:0]        dfx, dfy;
  logic [MagW-1:0]               mx, my;
  logic                          better;

  logic [DistW-1:0]              best_d_q;
  logic [AddrW-1:0]              best_i_q;
  logic [AngleW-1:0]             best_ax_q, best_ay_q;

  logic                          ov_q, ov_d;
  logic [AngleW-1:0]             oax_q, oay_q;
  logic [IndexW-1:0]             oidx_q;
  logic                          oempty_q;

  assign scan_len   = (entry_count_i > CountW'(StoreDepth)) ? CountW'(StoreDepth)
                                                             : entry_count_i;
  assign cmd_pop_o  = (state_q == StIdle) && cmd_valid_i;
  assign mem_we     = cmd_pop_o && (cmd_i.op == npal_pkg::OP_LOAD);
  assign take_query = cmd_pop_o && (cmd_i.op == npal_pkg::OP_QUERY);
  assign rd_en      = (state_q == StScan);
  assign out_load   = (state_q == StDone) && (!ov_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    empty_d = empty_q;
    case (state_q)
      StIdle: begin
        if (take_query) begin
          cnt_d  = '0;
          last_d = AddrW'(scan_len - CountW'(1));
          if (scan_len == '0) begin
            empty_d = 1'b1;
            state_d = StDone;
          end else begin
            empty_d = 1'b0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == last_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (v4_q && t4_q.last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    ex  = rd_q[MemW-1 -: COORD_BITS];
    ey  = rd_q[MemW-COORD_BITS-1 -: COORD_BITS];
    dfx = MagW'(ex) - MagW'(qx_q);
    dfy = MagW'(ey) - MagW'(qy_q);
    mx  = dfx[MagW-1] ? MagW'(-dfx) : MagW'(dfx);
    my  = dfy[MagW-1] ? MagW'(-dfy) : MagW'(dfy);
  end

  assign better = v4_q && (t4_q.first || (dist4_q < best_d_q));
  assign ov_d   = out_load || (ov_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= rd_en;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    last_q  <= last_d;
    empty_q <= empty_d;
    if (take_query) begin
      qx_q <= cmd_i.x[COORD_BITS-1:0];
      qy_q <= cmd_i.y[COORD_BITS-1:0];
    end
    t1_q    <= '{first: (cnt_q == '0), last: (cnt_q == last_q), idx: cnt_q};
    t2_q    <= t1_q;
    t3_q    <= t2_q;
    t4_q    <= t3_q;
    mx2_q   <= mx;
    my2_q   <= my;
    ax2_q   <= rd_q[2*AngleW-1 -: AngleW];
    ay2_q   <= rd_q[AngleW-1:0];
    sqx3_q  <= SqW'(mx2_q) * SqW'(mx2_q);
    sqy3_q  <= SqW'(my2_q) * SqW'(my2_q);
    ax3_q   <= ax2_q;
    ay3_q   <= ay2_q;
    dist4_q <= DistW'(sqx3_q) + DistW'(sqy3_q);
    ax4_q   <= ax3_q;
    ay4_q   <= ay3_q;
    if (better) begin
      best_d_q  <= dist4_q;
      best_i_q  <= t4_q.idx;
      best_ax_q <= ax4_q;
      best_ay_q <= ay4_q;
    end
    if (out_load) begin
      oempty_q <= empty_q;
      oax_q    <= empty_q ? '0 : best_ax_q;
      oay_q    <= empty_q ? '0 : best_ay_q;
      oidx_q   <= empty_q ? '0 : IndexW'(best_i_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[cmd_i.index[AddrW-1:0]] <= {cmd_i.x[COORD_BITS-1:0], cmd_i.y[COORD_BITS-1:0],
                                             cmd_i.angle_x, cmd_i.angle_y};
    end
    if (rd_en) begin
      rd_q <= table_mem[cnt_q];
    end
  end

  assign out_valid_o     = ov_q;
  assign found_angle_x_o = oax_q;
  assign found_angle_y_o = oay_q;
  assign found_index_o   = oidx_q;
  assign table_empty_o   = oempty_q;

endmodule

[hdl/nearest_point_angle_lookup.sv]
// Top level of the nearest point angle lookup: input stage, command queue and scan engine.
//
// Input words carry either a table load (req_type_i low) or a nearest-point query
// (req_type_i high). A load writes one slot of the point table; a load to a slot at
// or beyond the table depth is dropped. A query scans slots 0 to entry_count-1 (capped
// at the table depth) and returns one result word with the closest point's angles and
// index, the lowest index winning on ties; an empty scan sets table_empty_o in the result.
// A word is taken when its valid is high and its stall is low, on both channels.
// The input stage and a two-entry queue keep accepting words until the queue is full
// while the scan engine works or while a result waits on a stalled receiver; a held result
// stays unchanged. A load writes its slot as the scan engine pops it. A query reads its
// entries through the single table read port, which delivers one entry per cycle into a
// four-stage distance pipeline; an empty scan skips the table and goes straight to its
// result word. The user must write the count register with cfg_we_i only while no query
// is pending; the block itself does not enforce this. Reset clears the count, the queue
// and all handshakes; the table contents stay undefined until loaded.
module nearest_point_angle_lookup #(
  parameter int TABLE_DEPTH = 65536,
  parameter int COORD_BITS  = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [npal_pkg::CountW-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [npal_pkg::IndexW-1:0]        entry_index_i,
  input  logic signed [COORD_BITS-1:0]       point_x_i,
  input  logic signed [COORD_BITS-1:0]       point_y_i,
  input  logic signed [npal_pkg::AngleW-1:0] load_angle_x_i,
  input  logic signed [npal_pkg::AngleW-1:0] load_angle_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [npal_pkg::AngleW-1:0] found_angle_x_o,
  output logic signed [npal_pkg::AngleW-1:0] found_angle_y_o,
  output logic [npal_pkg::IndexW-1:0]        found_index_o,
  output logic                               table_empty_o
);

  logic [npal_pkg::CountW-1:0] count_q;
  npal_pkg::cmd_t              front_cmd, head_cmd;
  logic                        push, fifo_full, fifo_empty, cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  npal_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .load_angle_x_i (load_angle_x_i),
    .load_angle_y_i (load_angle_y_i),
    .cmd_o          (front_cmd),
    .push_o         (push),
    .full_i         (fifo_full)
  );

  npal_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .cmd_o   (head_cmd),
    .empty_o (fifo_empty)
  );

  npal_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (head_cmd),
    .cmd_valid_i     (!fifo_empty),
    .cmd_pop_o       (cmd_pop),
    .entry_count_i   (count_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_angle_x_o (found_angle_x_o),
    .found_angle_y_o (found_angle_y_o),
    .found_index_o   (found_index_o),
    .table_empty_o   (table_empty_o)
  );

  ap_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !fifo_empty)
    else $error("Scan engine popped an empty queue.");

  ap_full_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop && fifo_full |=> !fifo_full)
    else $error("Queue stayed full after a pop.");

  ap_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_empty_o |-> (found_index_o == '0) && (found_angle_x_o == '0)
                                     && (found_angle_y_o == '0))
    else $error("Empty-table result carries nonzero fields.");

endmodule

[sim/tb_nearest_point_angle_lookup.sv]
// Testbench for the nearest point angle lookup: directed and random loads and queries.
module tb_nearest_point_angle_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordW = 20;
  localparam int TableDepth = 65536;
  localparam int SettleCycles = 24;

  typedef struct {
    npal_pkg::op_e            op;
    logic [15:0]              slot;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [15:0]       ax;
    logic signed [15:0]       ay;
  } req_word_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic [15:0]        index;
    logic               empty;
  } hit_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [npal_pkg::CountW-1:0] cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        req_type_i;
  logic [15:0]                 entry_index_i;
  logic signed [CoordW-1:0]    point_x_i;
  logic signed [CoordW-1:0]    point_y_i;
  logic signed [15:0]          load_angle_x_i;
  logic signed [15:0]          load_angle_y_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [15:0]          found_angle_x_o;
  logic signed [15:0]          found_angle_y_o;
  logic [15:0]                 found_index_o;
  logic                        table_empty_o;

  int          tab_x [TableDepth];
  int          tab_y [TableDepth];
  bit [15:0]   tab_ax [TableDepth];
  bit [15:0]   tab_ay [TableDepth];
  int          scan_count;
  hit_t        expected_hits[$];
  hit_t        oldest_hit;
  int          mismatch_count;
  int          burst_left;
  bit          gaps_off;
  int          hold_off_left;
  stall_mode_e stall_mode;
  int          stall_mode_left;
  int          stall_tick;

  nearest_point_angle_lookup #(
    .TABLE_DEPTH(TableDepth),
    .COORD_BITS (CoordW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .load_angle_x_i (load_angle_x_i),
    .load_angle_y_i (load_angle_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_angle_x_o(found_angle_x_o),
    .found_angle_y_o(found_angle_y_o),
    .found_index_o  (found_index_o),
    .table_empty_o  (table_empty_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic hit_t nearest_entry(int px, int py);
    hit_t   hit;
    int     n;
    int     best;
    longint dx;
    longint dy;
    longint dsq;
    longint best_dsq;
    hit = '0;
    n = scan_count;
    if (n > TableDepth) n = TableDepth;
    if (n > npal_pkg::SlotLimit) n = npal_pkg::SlotLimit;
    if (n == 0) begin
      hit.empty = 1'b1;
      return hit;
    end
    best = 0;
    best_dsq = 0;
    for (int i = 0; i < n; i++) begin
      dx = longint'(tab_x[i]) - longint'(px);
      dy = longint'(tab_y[i]) - longint'(py);
      dsq = dx * dx + dy * dy;
      if (i == 0 || dsq < best_dsq) begin
        best_dsq = dsq;
        best = i;
      end
    end
    hit.angle_x = tab_ax[best];
    hit.angle_y = tab_ay[best];
    hit.index = best[15:0];
    return hit;
  endfunction

  function automatic req_word_t load_word(int slot, int x, int y, int ax, int ay);
    req_word_t w;
    w.op = npal_pkg::OP_LOAD;
    w.slot = slot[15:0];
    w.px = x[CoordW-1:0];
    w.py = y[CoordW-1:0];
    w.ax = ax[15:0];
    w.ay = ay[15:0];
    return w;
  endfunction

  function automatic req_word_t query_word(int x, int y);
    req_word_t w;
    w = load_word($urandom_range(0, 65535), x, y, $urandom, $urandom);
    w.op = npal_pkg::OP_QUERY;
    return w;
  endfunction

  function automatic int rand_coord(bit wide);
    if (wide) return int'($urandom_range(0, 1048575)) - 524288;
    return int'($urandom_range(0, 16)) - 8;
  endfunction

  function automatic int rand_angle();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ERROR: %s", $time, msg);
  endtask

  task automatic send_word(req_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = gaps_off ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    req_type_i = (w.op == npal_pkg::OP_QUERY);
    entry_index_i = w.slot;
    point_x_i = w.px;
    point_y_i = w.py;
    load_angle_x_i = w.ax;
    load_angle_y_i = w.ay;
    do @(posedge clk_i); while (in_stall_o);
    if (w.op == npal_pkg::OP_LOAD) begin
      tab_x[w.slot] = w.px;
      tab_y[w.slot] = w.py;
      tab_ax[w.slot] = w.ax;
      tab_ay[w.slot] = w.ay;
    end else begin
      expected_hits.insert(expected_hits.size(), nearest_entry(w.px, w.py));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(int value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_we_i = 1'b1;
    cfg_wdata_i = value[npal_pkg::CountW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    scan_count = value & 32'h1FFFF;
  endtask

  task automatic test_empty_table();
    send_word(query_word(-524288, 524287));
    wait_idle();
    write_count(0);
    send_word(query_word(524287, -524288));
    send_word(query_word(0, 0));
    wait_idle();
  endtask

  task automatic test_directed_points();
    send_word(load_word(0, -524288, -524288, -32768, 32767));
    send_word(load_word(1, 524287, 524287, 32767, -32768));
    send_word(load_word(2, 100, 0, 1, 2));
    send_word(load_word(3, -100, 0, 3, 4));
    send_word(load_word(4, 100, 0, 5, 6));
    send_word(load_word(5, 0, 1000, 0, 0));
    send_word(load_word(6, -524288, 524287, -1, -1));
    send_word(load_word(7, 524287, -524288, 1000, -1000));
    send_word(load_word(65535, 524287, 524287, -32768, -32768));
    wait_idle();
    write_count(1);
    send_word(query_word(524287, 524287));
    wait_idle();
    write_count(8);
    send_word(query_word(0, 0));
    send_word(query_word(-524288, -524288));
    send_word(query_word(524287, 524287));
    send_word(query_word(524287, -524288));
    send_word(query_word(100, 0));
    send_word(query_word(0, 999));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int  n;
    bit  wide;
    int  slot;
    for (int phase = 0; phase < 4; phase++) begin
      n = (phase == 0) ? 1 : $urandom_range(2, 16);
      wide = phase[0];
      write_count(n);
      for (int i = 0; i < n; i++) begin
        send_word(load_word(i, rand_coord(wide), rand_coord(wide), rand_angle(), rand_angle()));
      end
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, n + 8);
          send_word(load_word(slot, rand_coord(wide), rand_coord(wide),
                              rand_angle(), rand_angle()));
        end else begin
          send_word(query_word(rand_coord(wide), rand_coord(wide)));
        end
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    gaps_off = 1'b1;
    hold_off_left = 300;
    for (int k = 0; k < 12; k++) begin
      send_word(query_word(rand_coord(k[0]), rand_coord(k[0])));
    end
    gaps_off = 1'b0;
    wait_idle();
  endtask

  always @(negedge clk_i) begin
    if (stall_mode_left <= 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(16, 96);
    end
    stall_mode_left--;
    stall_tick++;
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall_i = 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE: out_stall_i = 1'b0;
        STALL_LIGHT: out_stall_i = ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall_i = ((stall_tick % 5) < 2);
        default: out_stall_i = ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result word with no query waiting");
      end else begin
        oldest_hit = expected_hits.pop_front();
        if (found_angle_x_o !== oldest_hit.angle_x)
          report_mismatch($sformatf("found_angle_x %0d, want %0d",
                                    found_angle_x_o, oldest_hit.angle_x));
        if (found_angle_y_o !== oldest_hit.angle_y)
          report_mismatch($sformatf("found_angle_y %0d, want %0d",
                                    found_angle_y_o, oldest_hit.angle_y));
        if (found_index_o !== oldest_hit.index)
          report_mismatch($sformatf("found_index %0d, want %0d",
                                    found_index_o, oldest_hit.index));
        if (table_empty_o !== oldest_hit.empty)
          report_mismatch($sformatf("table_empty %b, want %b",
                                    table_empty_o, oldest_hit.empty));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("nearest_point_angle_lookup: mismatch");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    req_type_i = 1'b0;
    entry_index_i = '0;
    point_x_i = '0;
    point_y_i = '0;
    load_angle_x_i = '0;
    load_angle_y_i = '0;
    out_stall_i = 1'b0;
    scan_count = 0;
    mismatch_count = 0;
    burst_left = 0;
    gaps_off = 1'b0;
    hold_off_left = 0;
    stall_mode = STALL_NONE;
    stall_mode_left = 0;
    stall_tick = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_table();
    test_directed_points();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("nearest_point_angle_lookup: match");
    end else begin
      $display("nearest_point_angle_lookup: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/npal_pkg.sv
hdl/npal_front.sv
hdl/npal_fifo.sv
hdl/npal_back.sv
hdl/nearest_point_angle_lookup.sv
sim/tb_nearest_point_angle_lookup.sv
